[design/rla_pkg.sv]
package rla_pkg;

    // Vector length and history depth.
    localparam int DIM    = 4;
    localparam int WINDOW = 16;

    localparam int IDX_W  = 2;   // bits of a component index
    localparam int LAG_W  = 4;   // bits of a lag or history slot
    localparam int FILL_W = 5;   // bits that hold 0..WINDOW
    localparam int HIST_AW = LAG_W + IDX_W;
    localparam int HIST_DEPTH = WINDOW * DIM;

    // Moment store layout: lagged matrices first, then the second moment,
    // the mean and the per-lag contribution counts.
    localparam int MEM_AW    = 9;
    localparam int MEM_DEPTH = 512;
    localparam logic [MEM_AW-1:0] SM_BASE   = 9'h100;
    localparam logic [MEM_AW-1:0] MEAN_BASE = 9'h110;
    localparam logic [MEM_AW-1:0] CNT_BASE  = 9'h120;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_MEAN   = 2'd1,
        OP_COV    = 2'd2,
        OP_AUTO   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_FEW = 2'd1,
        STAT_LAG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        GRP_MEAN = 2'd0,
        GRP_SM   = 2'd1,
        GRP_LAG  = 2'd2,
        GRP_COV  = 2'd3
    } grp_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        begin
            s = a + b;
            if ((a[63] == b[63]) && (s[63] != a[63]))
                s = a[63] ? S64_MIN : S64_MAX;
            return s;
        end
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        begin
            s = a - b;
            if ((a[63] != b[63]) && (s[63] != a[63]))
                s = a[63] ? S64_MIN : S64_MAX;
            return s;
        end
    endfunction

endpackage

[design/running_lagged_autocovariance.sv]
// One word is in flight; the next can be taken in the same cycle its result is offered, later
// under a receiver stall. A status-only answer, a mean or an autocovariance needs no division;
// a covariance goes through the shared bit-serial divider. In a record every moment entry is
// read, formed, divided bit-serially and written back; a first contribution is written directly.
// Reset (asynchronous, active low) clears count, fill and lag flags; window_length becomes 16.
module running_lagged_autocovariance
    import rla_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] sample_x0,
    input  logic signed [31:0] sample_x1,
    input  logic signed [31:0] sample_x2,
    input  logic signed [31:0] sample_x3,
    input  logic [3:0]         lag,
    input  logic [1:0]         row,
    input  logic [1:0]         col,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] value,
    output logic [1:0]         status,
    output logic [31:0]        count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    // Sequencer states. A record walks the mean, the second moment and then
    // each filled lag; every entry is read, its target formed (by the
    // multiplier but for a mean entry), divided and written back. Covariance
    // and autocovariance reads fetch both mean components, form their product
    // in four partial products and combine it with the stored moment.
    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_PUSH    = 16'h0002,
        S_ENT_RD  = 16'h0004,
        S_ENT_MUL = 16'h0008,
        S_ENT_SUB = 16'h0010,
        S_DIV     = 16'h0020,
        S_ENT_WR  = 16'h0040,
        S_LCNT_RD = 16'h0080,
        S_LCNT_WT = 16'h0100,
        S_RD_MB   = 16'h0200,
        S_MB      = 16'h0400,
        S_MUL     = 16'h0800,
        S_MM      = 16'h1000,
        S_RD_FIN  = 16'h2000,
        S_COV_FIN = 16'h4000,
        S_DONE    = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // Control state.
    logic [31:0]        total_reg, total_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [LAG_W-1:0]   head_reg, head_next;
    logic [WINDOW-1:0]  lag_valid_reg, lag_valid_next;
    logic [4:0]         wl_reg, wl_next;
    logic               out_valid_reg, out_valid_next;

    // Word and walk registers.
    op_t                op_reg;
    logic signed [31:0] x_reg [DIM];
    logic [LAG_W-1:0]   lag_reg;
    logic [IDX_W-1:0]   row_reg, col_reg;
    grp_t               grp_reg, grp_next;
    logic [IDX_W-1:0]   i_reg, i_next, j_reg, j_next;
    logic [LAG_W-1:0]   k_reg, k_next;
    logic [31:0]        cnt_reg, cnt_next;
    logic signed [63:0] old_reg, target_reg;
    logic signed [63:0] res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;
    logic signed [63:0] value_reg;
    status_t            status_reg;
    logic [31:0]        count_reg;

    // Product of two mean components.
    logic signed [63:0] ma_reg, mm_reg;
    logic [63:0]        ua_reg, ub_reg;
    logic               mneg_reg;
    logic [2:0]         step_reg;
    logic [63:0]        pp_reg;
    logic [127:0]       acc_reg;

    // Bit-serial divider.
    logic               div_start;
    logic signed [63:0] div_dividend;
    logic [31:0]        div_divisor;
    logic [63:0]        div_quo_reg;
    logic [31:0]        div_rem_reg, div_den_reg;
    logic [5:0]         div_cnt_reg;
    logic               div_neg_reg;
    logic [32:0]        div_shift;
    logic               div_ge;
    logic signed [63:0] div_q;

    // Memories.
    logic [63:0]        mem [MEM_DEPTH];
    logic [63:0]        mem_rdata;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_wa, mem_ra;
    logic [63:0]        mem_wd;
    logic [31:0]        hist [HIST_DEPTH];
    logic signed [31:0] hist_rdata;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_wa, hist_ra;
    logic [31:0]        hist_wd;

    logic [FILL_W-1:0]  w_eff;
    logic [FILL_W-1:0]  fill_inc;
    logic [MEM_AW-1:0]  ent_addr;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic [63:0]        mm_mag;
    logic signed [63:0] mm_val;
    logic signed [63:0] rd_diff;
    logic [31:0]        cnt_new;
    logic               in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign count     = count_reg;

    // Zero acts as one, anything above the history depth as the full depth.
    always_comb
    begin
        if (wl_reg == 5'd0)
            w_eff = FILL_W'(1);
        else if (wl_reg > FILL_W'(WINDOW))
            w_eff = FILL_W'(WINDOW);
        else
            w_eff = wl_reg;
    end

    always_comb
    begin
        case (grp_reg)
            GRP_MEAN: ent_addr = MEAN_BASE + MEM_AW'(i_reg);
            GRP_SM:   ent_addr = SM_BASE + MEM_AW'({i_reg, j_reg});
            default:  ent_addr = MEM_AW'({k_reg, i_reg, j_reg});
        endcase
    end

    assign mul_b = (grp_reg == GRP_LAG) ? hist_rdata : x_reg[j_reg];
    assign mul_p = 64'(x_reg[i_reg]) * 64'(mul_b);

    // Divider step: restoring, one quotient bit per cycle.
    assign div_shift = {div_rem_reg, div_quo_reg[63]};
    assign div_ge    = (div_shift >= {1'b0, div_den_reg});
    assign div_q     = div_neg_reg ? -$signed(div_quo_reg) : $signed(div_quo_reg);

    // Product of two Q48.16 means, truncated to an integer, with saturation.
    assign mm_mag = acc_reg[95:32];
    always_comb
    begin
        if (|acc_reg[127:95])
            mm_val = mneg_reg ? S64_MIN : S64_MAX;
        else
            mm_val = mneg_reg ? -$signed(mm_mag) : $signed(mm_mag);
    end

    assign rd_diff = sat_sub($signed(mem_rdata), mm_reg);
    assign cnt_new = !lag_valid_reg[k_reg] ? 32'd1
                   : ((mem_rdata[31:0] == COUNT_MAX) ? COUNT_MAX : mem_rdata[31:0] + 32'd1);
    assign fill_inc = (fill_reg < FILL_W'(WINDOW)) ? fill_reg + FILL_W'(1) : fill_reg;

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        lag_valid_next  = lag_valid_reg;
        wl_next         = wl_reg;
        out_valid_next  = out_valid_reg;
        grp_next        = grp_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_wa          = ent_addr;
        mem_wd          = target_reg;
        mem_ra          = ent_addr;
        hist_we         = 1'b0;
        hist_wa         = {head_reg, j_reg};
        hist_wd         = x_reg[j_reg];
        hist_ra         = {head_reg - k_reg, j_reg};
        div_start       = 1'b0;
        div_dividend    = sat_sub(target_reg, old_reg);
        div_divisor     = cnt_reg;

        if (cfg_valid && cfg_ready)
            wl_next = cfg_data;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                mem_ra = MEAN_BASE + MEM_AW'(row);
                if (in_fire)
                begin
                    res_value_next  = '0;
                    res_status_next = STAT_OK;
                    case (op_t'(operation))
                        OP_RECORD:
                        begin
                            total_next = (total_reg == COUNT_MAX) ? COUNT_MAX
                                                                  : total_reg + 32'd1;
                            fill_next  = (fill_inc > w_eff) ? w_eff : fill_inc;
                            head_next  = head_reg + LAG_W'(1);
                            for (int k = 0; k < WINDOW; k++)
                            begin
                                if (FILL_W'(k) >= w_eff)
                                    lag_valid_next[k] = 1'b0;
                            end
                            j_next     = '0;
                            state_next = S_PUSH;
                        end
                        OP_MEAN:
                        begin
                            if (int'(row) >= DIM)
                                state_next = S_DONE;
                            else if (total_reg == 32'd0)
                            begin
                                res_status_next = STAT_FEW;
                                state_next      = S_DONE;
                            end
                            else
                                state_next = S_RD_MB;
                        end
                        OP_COV:
                        begin
                            if (int'(row) >= DIM || int'(col) >= DIM)
                                state_next = S_DONE;
                            else if (total_reg < 32'd2)
                            begin
                                res_status_next = STAT_FEW;
                                state_next      = S_DONE;
                            end
                            else
                                state_next = S_RD_MB;
                        end
                        default:
                        begin
                            if (int'(row) >= DIM || int'(col) >= DIM)
                                state_next = S_DONE;
                            else if (FILL_W'(lag) >= w_eff || !lag_valid_reg[lag])
                            begin
                                res_status_next = STAT_LAG;
                                state_next      = S_DONE;
                            end
                            else
                                state_next = S_RD_MB;
                        end
                    endcase
                end
            end

            // The new sample goes into the slot after the current newest.
            S_PUSH:
            begin
                hist_we = 1'b1;
                j_next  = j_reg + IDX_W'(1);
                if (int'(j_reg) == DIM - 1)
                begin
                    grp_next   = GRP_MEAN;
                    i_next     = '0;
                    j_next     = '0;
                    cnt_next   = total_reg;
                    state_next = S_ENT_RD;
                end
            end

            S_ENT_RD:
                state_next = S_ENT_MUL;

            S_ENT_MUL:
                state_next = S_ENT_SUB;

            S_ENT_SUB:
            begin
                if (cnt_reg == 32'd1)
                begin
                    mem_we = 1'b1;
                    state_next = S_ENT_WR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_cnt_reg == 6'd63)
                    state_next = (grp_reg == GRP_COV) ? S_COV_FIN : S_ENT_WR;
            end

            // Write back (unless the first contribution was written already) and move on.
            S_ENT_WR:
            begin
                if (cnt_reg != 32'd1)
                begin
                    mem_we = 1'b1;
                    mem_wd = sat_add(old_reg, div_q);
                end
                state_next = S_ENT_RD;
                case (grp_reg)
                    GRP_MEAN:
                    begin
                        i_next = i_reg + IDX_W'(1);
                        if (int'(i_reg) == DIM - 1)
                        begin
                            grp_next = GRP_SM;
                            i_next   = '0;
                            j_next   = '0;
                        end
                    end
                    default:
                    begin
                        j_next = j_reg + IDX_W'(1);
                        if (int'(j_reg) == DIM - 1)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                            if (int'(i_reg) == DIM - 1)
                            begin
                                i_next = '0;
                                if (grp_reg == GRP_SM)
                                begin
                                    k_next     = '0;
                                    state_next = S_LCNT_RD;
                                end
                                else if ((FILL_W'(k_reg) + FILL_W'(1)) < fill_reg)
                                begin
                                    k_next     = k_reg + LAG_W'(1);
                                    state_next = S_LCNT_RD;
                                end
                                else
                                    state_next = S_DONE;
                            end
                        end
                    end
                endcase
            end

            S_LCNT_RD:
            begin
                mem_ra     = CNT_BASE + MEM_AW'(k_reg);
                state_next = S_LCNT_WT;
            end

            S_LCNT_WT:
            begin
                mem_we                = 1'b1;
                mem_wa                = CNT_BASE + MEM_AW'(k_reg);
                mem_wd                = {32'd0, cnt_new};
                cnt_next              = cnt_new;
                lag_valid_next[k_reg] = 1'b1;
                grp_next              = GRP_LAG;
                i_next                = '0;
                j_next                = '0;
                state_next            = S_ENT_RD;
            end

            S_RD_MB:
            begin
                mem_ra = MEAN_BASE + MEM_AW'(col_reg);
                if (op_reg == OP_MEAN)
                begin
                    res_value_next = $signed(mem_rdata);
                    state_next     = S_DONE;
                end
                else
                    state_next = S_MB;
            end

            S_MB:
                state_next = S_MUL;

            S_MUL:
            begin
                if (step_reg == 3'd4)
                    state_next = S_MM;
            end

            S_MM:
            begin
                if (op_reg == OP_COV)
                    mem_ra = SM_BASE + MEM_AW'({row_reg, col_reg});
                else
                    mem_ra = MEM_AW'({lag_reg, row_reg, col_reg});
                state_next = S_RD_FIN;
            end

            S_RD_FIN:
            begin
                if (op_reg == OP_AUTO)
                begin
                    res_value_next = rd_diff;
                    state_next     = S_DONE;
                end
                else
                begin
                    grp_next     = GRP_COV;
                    div_start    = 1'b1;
                    div_dividend = rd_diff;
                    div_divisor  = total_reg - 32'd1;
                    state_next   = S_DIV;
                end
            end

            S_COV_FIN:
            begin
                res_value_next = sat_add(old_reg, div_q);
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            lag_valid_reg <= '0;
            wl_reg        <= 5'd16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            lag_valid_reg <= lag_valid_next;
            wl_reg        <= wl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg        <= grp_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        cnt_reg        <= cnt_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;

        if (in_fire)
        begin
            op_reg   <= op_t'(operation);
            x_reg[0] <= sample_x0;
            x_reg[1] <= sample_x1;
            x_reg[2] <= sample_x2;
            x_reg[3] <= sample_x3;
            lag_reg  <= lag;
            row_reg  <= row;
            col_reg  <= col;
        end

        if (state_reg == S_ENT_MUL)
        begin
            old_reg <= $signed(mem_rdata);
            if (grp_reg == GRP_MEAN)
                target_reg <= {{16{x_reg[i_reg][31]}}, x_reg[i_reg], 16'd0};
            else
                target_reg <= mul_p;
        end
        else if (state_reg == S_RD_FIN)
            old_reg <= rd_diff;

        if (state_reg == S_RD_MB)
            ma_reg <= $signed(mem_rdata);

        if (state_reg == S_MB)
        begin
            mneg_reg <= ma_reg[63] ^ mem_rdata[63];
            ua_reg   <= ma_reg[63] ? 64'(-ma_reg) : 64'(ma_reg);
            ub_reg   <= mem_rdata[63] ? -mem_rdata : mem_rdata;
            step_reg <= '0;
            acc_reg  <= '0;
        end
        else if (state_reg == S_MUL)
        begin
            step_reg <= step_reg + 3'd1;
            case (step_reg)
                3'd0:    pp_reg <= ua_reg[31:0] * ub_reg[31:0];
                3'd1:    pp_reg <= ua_reg[31:0] * ub_reg[63:32];
                3'd2:    pp_reg <= ua_reg[63:32] * ub_reg[31:0];
                3'd3:    pp_reg <= ua_reg[63:32] * ub_reg[63:32];
                default: pp_reg <= '0;
            endcase
            case (step_reg)
                3'd1:    acc_reg <= acc_reg + {64'd0, pp_reg};
                3'd2:    acc_reg <= acc_reg + {32'd0, pp_reg, 32'd0};
                3'd3:    acc_reg <= acc_reg + {32'd0, pp_reg, 32'd0};
                3'd4:    acc_reg <= acc_reg + {pp_reg, 64'd0};
                default: acc_reg <= acc_reg;
            endcase
        end

        if (state_reg == S_MM)
            mm_reg <= mm_val;

        if (div_start)
        begin
            div_neg_reg <= div_dividend[63];
            div_quo_reg <= div_dividend[63] ? 64'(-div_dividend) : 64'(div_dividend);
            div_rem_reg <= '0;
            div_den_reg <= div_divisor;
            div_cnt_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            div_rem_reg <= div_ge ? 32'(div_shift - {1'b0, div_den_reg}) : div_shift[31:0];
            div_quo_reg <= {div_quo_reg[62:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end

        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            value_reg  <= res_value_reg;
            status_reg <= res_status_reg;
            count_reg  <= total_reg;
        end
    end

    // Moment store: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_rdata <= mem[mem_ra];
    end

    // Sample history as a ring: slot head holds the newest sample.
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist[hist_wa] <= hist_wd;
        hist_rdata <= $signed(hist[hist_ra]);
    end

endmodule
